// ===== hdl/itoa_pkg.sv =====
// shared constants, types and the controller state encoding for the decimal text converter
package itoa_pkg;

	localparam int VALUE_BITS = 32;

	// decimal digits of 2^(VALUE_BITS-1), the largest magnitude
	function automatic int num_digits(input int bits);
		logic [64:0] v;
		int n;
		v = 65'd1 << (bits - 1);
		n = 0;
		for (int i = 0; i < 21; i++) begin
			if (v != 65'd0) begin
				n = n + 1;
				v = v / 65'd10;
			end
		end
		return n;
	endfunction

	localparam int MAX_DIGITS = num_digits(VALUE_BITS);
	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	// reciprocal of ten, rounded up, scaled by 2^(VALUE_BITS+3)
	localparam int RECIP_SHIFT = VALUE_BITS + 3;
	localparam logic [VALUE_BITS+3:0] RECIP_POW = {1'b1, {(VALUE_BITS + 3){1'b0}}};
	localparam logic [VALUE_BITS+3:0] RECIP_FULL = (RECIP_POW + 9) / 10;
	localparam logic [VALUE_BITS-1:0] RECIP = RECIP_FULL[VALUE_BITS-1:0];

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic div;
		logic show_sign;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic neg;
		logic quo_zero;
		logic rd_zero;
	} sts_t;

endpackage

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// top level: signed integer to decimal ascii text, controller plus datapath
//
//   channel   handshake                  fields
//   input     value_valid / value_stall  value
//   output    char_valid / char_stall    character, last
//
// an item is loaded, then takes a multiply and a divide step for each of its decimal digits,
// then an output step for each of its characters, the sign included
// each digit uses the shared divide-by-ten multiplier
// reset clears the state machine and counters, the digit store is not reset
// char_stall holds the current character, value_stall is high until the run ends
module signed_int_to_decimal_ascii (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  value_valid,
	output logic                                  value_stall,
	input  logic signed [itoa_pkg::VALUE_BITS-1:0] value,
	output logic                                  char_valid,
	input  logic                                  char_stall,
	output logic [7:0]                            character,
	output logic                                  last
);

	itoa_pkg::cmd_t cmd;
	itoa_pkg::sts_t sts;

	itoa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	itoa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.character (character),
		.last      (last)
	);

endmodule

// ===== hdl/itoa_dp.sv =====
// datapath: magnitude, divide-by-ten multiplier, digit store and character output
module itoa_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [itoa_pkg::VALUE_BITS-1:0] value,
	input  itoa_pkg::cmd_t                        cmd,
	output itoa_pkg::sts_t                        sts,
	output logic [7:0]                            character,
	output logic                                  last
);

	logic [itoa_pkg::VALUE_BITS-1:0]   mag_q;
	logic                              neg_q;
	logic [2*itoa_pkg::VALUE_BITS-1:0] prod_q;
	logic [3:0]                        dig_q [itoa_pkg::MAX_DIGITS];
	logic [itoa_pkg::CNT_W-1:0]        ndig_q;
	logic [itoa_pkg::IDX_W-1:0]        rd_q;

	logic [itoa_pkg::VALUE_BITS-4:0]   quo;
	logic [itoa_pkg::VALUE_BITS-1:0]   quo_ext;
	logic [itoa_pkg::VALUE_BITS-1:0]   quo_x10;
	logic [itoa_pkg::VALUE_BITS-1:0]   rem;
	logic [itoa_pkg::VALUE_BITS-1:0]   raw;

	assign raw = value;
	assign quo = prod_q[2*itoa_pkg::VALUE_BITS-1:itoa_pkg::RECIP_SHIFT];
	assign quo_ext = {3'b000, quo};
	assign quo_x10 = (quo_ext << 3) + (quo_ext << 1);
	assign rem = mag_q - quo_x10;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndig_q <= '0;
			rd_q   <= '0;
		end else begin
			if (cmd.load) begin
				ndig_q <= '0;
			end else if (cmd.div) begin
				ndig_q <= ndig_q + 1'b1;
				rd_q   <= ndig_q[itoa_pkg::IDX_W-1:0];
			end else if (cmd.pop) begin
				rd_q <= rd_q - 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= raw[itoa_pkg::VALUE_BITS-1];
			mag_q <= raw[itoa_pkg::VALUE_BITS-1] ? (~raw + 1'b1) : raw;
		end else if (cmd.div) begin
			mag_q <= quo_ext;
		end
		if (cmd.mul) begin
			prod_q <= mag_q * itoa_pkg::RECIP;
		end
		if (cmd.div) begin
			dig_q[ndig_q[itoa_pkg::IDX_W-1:0]] <= rem[3:0];
		end
	end

	assign sts.neg = neg_q;
	assign sts.quo_zero = (quo == '0);
	assign sts.rd_zero = (rd_q == '0);

	assign character = cmd.show_sign ? itoa_pkg::CHAR_MINUS
		: (itoa_pkg::CHAR_ZERO + {4'b0000, dig_q[rd_q]});
	assign last = !cmd.show_sign && (rd_q == '0);

endmodule

// ===== hdl/itoa_ctrl.sv =====
// controller state machine sequencing load, digit extraction and character output
module itoa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           value_valid,
	output logic           value_stall,
	output logic           char_valid,
	input  logic           char_stall,
	input  itoa_pkg::sts_t sts,
	output itoa_pkg::cmd_t cmd
);

	itoa_pkg::state_t state_q;
	itoa_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			itoa_pkg::ST_IDLE: begin
				if (value_valid) begin
					state_nxt = itoa_pkg::ST_MUL;
				end
			end
			itoa_pkg::ST_MUL: begin
				state_nxt = itoa_pkg::ST_DIV;
			end
			itoa_pkg::ST_DIV: begin
				if (sts.quo_zero) begin
					state_nxt = sts.neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
				end else begin
					state_nxt = itoa_pkg::ST_MUL;
				end
			end
			itoa_pkg::ST_SIGN: begin
				if (!char_stall) begin
					state_nxt = itoa_pkg::ST_EMIT;
				end
			end
			itoa_pkg::ST_EMIT: begin
				if (!char_stall && sts.rd_zero) begin
					state_nxt = itoa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = itoa_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		value_stall = 1'b1;
		char_valid = 1'b0;
		case (state_q)
			itoa_pkg::ST_IDLE: begin
				value_stall = 1'b0;
				cmd.load = value_valid;
			end
			itoa_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
			end
			itoa_pkg::ST_DIV: begin
				cmd.div = 1'b1;
			end
			itoa_pkg::ST_SIGN: begin
				char_valid = 1'b1;
				cmd.show_sign = 1'b1;
			end
			itoa_pkg::ST_EMIT: begin
				char_valid = 1'b1;
				cmd.pop = !char_stall;
			end
			default: begin
				value_stall = 1'b1;
			end
		endcase
	end

`ifndef SYNTHESIS
	// never take a new item while characters are going out
	assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> value_stall)
		else $error("item taken while characters pending");

	// the marked character ends the run
	assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !char_stall && !cmd.show_sign && sts.rd_zero) |=> !char_valid)
		else $error("character after the last one");

	// no character is offered in the cycle after an item is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(value_valid && !value_stall) |=> !char_valid)
		else $error("character without conversion");

	// digits are only written while converting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div |-> !char_valid && value_stall)
		else $error("digit step during output");
`endif

endmodule

// ===== dv/itoa_text_checker.sv =====
// checker for the decimal text converter: predicts each number's characters and compares
module itoa_text_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   value_valid,
	input  logic                                   value_stall,
	input  logic signed [itoa_pkg::VALUE_BITS-1:0] value,
	input  logic                                   char_valid,
	input  logic                                   char_stall,
	input  logic [7:0]                             character,
	input  logic                                   last,
	output int                                     mismatches,
	output int                                     pending,
	output int                                     values_seen,
	output int                                     chars_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] ch;
		logic       last_mark;
	} text_char_t;

	text_char_t expected_text[$];

	initial begin
		mismatches = 0;
		pending = 0;
		values_seen = 0;
		chars_seen = 0;
	end

	// sign first, then digits most significant first, last mark on the final digit
	function automatic void queue_decimal_text(input logic [itoa_pkg::VALUE_BITS-1:0] raw);
		logic [itoa_pkg::VALUE_BITS-1:0] magnitude;
		logic [7:0] digits_rev [0:itoa_pkg::MAX_DIGITS-1];
		logic negative;
		int ndig;
		negative = raw[itoa_pkg::VALUE_BITS-1];
		// unsigned negate keeps the most negative value exact
		magnitude = negative ? (~raw + 1'b1) : raw;
		ndig = 0;
		do begin
			digits_rev[ndig] = itoa_pkg::CHAR_ZERO + 8'(magnitude % 10);
			ndig++;
			magnitude = magnitude / 10;
		end while (magnitude != 0);
		if (negative)
			expected_text.push_back('{ch: itoa_pkg::CHAR_MINUS, last_mark: 1'b0});
		for (int k = ndig - 1; k >= 0; k--)
			expected_text.push_back('{ch: digits_rev[k], last_mark: (k == 0)});
	endfunction

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (value_valid && !value_stall) begin
				queue_decimal_text(value);
				values_seen++;
			end
			if (char_valid && !char_stall) begin
				chars_seen++;
				if (expected_text.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected character 0x%02h last=%0b", $time,
							character, last);
				end else begin
					want = expected_text.pop_front();
					if (character !== want.ch || last !== want.last_mark) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected 0x%02h last=%0b, got 0x%02h last=%0b",
								$time, want.ch, want.last_mark, character, last);
					end
				end
			end
			pending = expected_text.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// top of the decimal text converter testbench: clock, reset, stimulus and verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int NUM_CORNERS = 18;

	logic                                   clk;
	logic                                   arst_n;
	logic                                   value_valid;
	logic                                   value_stall;
	logic signed [itoa_pkg::VALUE_BITS-1:0] value;
	logic                                   char_valid;
	logic                                   char_stall;
	logic [7:0]                             character;
	logic                                   last;

	int mismatches;
	int pending;
	int values_seen;
	int chars_seen;
	int idle_cycles;
	int errors;
	bit sender_eager;
	bit reader_eager;

	logic signed [31:0] corner_values [0:NUM_CORNERS-1] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, -32'sd9,
		32'sd100, 32'sd12345, 32'sd999999999, 32'sd1000000000, -32'sd1000000000,
		32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001, 32'sh55555555, 32'shAAAAAAAA
	};

	signed_int_to_decimal_ascii dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.character   (character),
		.last        (last)
	);

	itoa_text_checker text_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.character   (character),
		.last        (last),
		.mismatches  (mismatches),
		.pending     (pending),
		.values_seen (values_seen),
		.chars_seen  (chars_seen)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// called just after a falling edge, returns just after a falling edge
	task automatic send_value(input logic signed [31:0] v);
		int gap;
		gap = sender_eager ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			value_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		value_valid = 1'b1;
		value = v;
		do @(posedge clk); while (value_stall);
		@(negedge clk);
	endtask

	task automatic wait_text_drained();
		value_valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// mix of full-range words, short numbers, powers of ten and random digit counts
	function automatic logic signed [31:0] random_value();
		longint mag;
		longint lo;
		longint hi;
		int ndig;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: mag = $urandom_range(0, 99);
			2: begin
				mag = 1;
				repeat ($urandom_range(0, 9)) mag = mag * 10;
				mag = mag + $urandom_range(0, 2) - 1;
			end
			default: begin
				ndig = $urandom_range(1, 10);
				lo = 1;
				repeat (ndig - 1) lo = lo * 10;
				hi = (ndig == 10) ? 64'd2147483647 : lo * 10 - 1;
				if (ndig == 1)
					lo = 0;
				mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
			end
		endcase
		if ($urandom_range(0, 1))
			mag = -mag;
		return 32'(mag);
	endfunction

	task automatic send_random_values(input int count);
		repeat (count) send_value(random_value());
	endtask

	// receiver: holds stall for a drawn number of cycles, then takes one character
	initial begin
		int hold;
		char_stall = 1'b1;
		forever begin
			hold = reader_eager ? 0 : $urandom_range(0, 7);
			if (hold > 0) begin
				char_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			char_stall = 1'b0;
			do @(posedge clk); while (!char_valid);
			@(negedge clk);
		end
	end

	// watchdog on cycles in which neither channel moves an item
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((value_valid && !value_stall) || (char_valid && !char_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		sender_eager = 1'b0;
		reader_eager = 1'b0;
		value_valid = 1'b0;
		value = '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NUM_CORNERS; i++)
			send_value(corner_values[i]);
		wait_text_drained();

		send_random_values(40);
		wait_text_drained();

		// back to back on both sides
		sender_eager = 1'b1;
		reader_eager = 1'b1;
		send_random_values(36);
		wait_text_drained();

		// slow reader, first behind an eager sender and then behind a slow one
		reader_eager = 1'b0;
		send_random_values(18);
		sender_eager = 1'b0;
		send_random_values(18);
		wait_text_drained();

		repeat (DRAIN_CYCLES) @(negedge clk);
		errors = mismatches + pending;
		$display("converted %0d values (%0d corner cases incl. zero and both extremes)",
			values_seen, NUM_CORNERS);
		$display("checked %0d characters, %0d mismatches, %0d missing", chars_seen,
			mismatches, pending);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/itoa_pkg.sv
hdl/itoa_dp.sv
hdl/itoa_ctrl.sv
hdl/signed_int_to_decimal_ascii.sv
dv/itoa_text_checker.sv
dv/testbench.sv
